>>> rtl/hsv_to_rgb_converter_core_macros.svh
// assertion macros for the hsv to rgb converter
`ifndef HSV_TO_RGB_CONVERTER_CORE_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define HSVRGB_ASSERT_CR(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("hsv_to_rgb_converter_core: check failed");
`define HSVRGB_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("hsv_to_rgb_converter_core: check failed");
`else
`define HSVRGB_ASSERT_CR(label, clk, rst, prop)
`define HSVRGB_ASSERT(label, prop)
`endif

`endif

>>> rtl/hsvrgb_pkg.sv
// shared constants and types for the hsv to rgb converter
`default_nettype none

package hsvrgb_pkg;

   localparam int unsigned HUE_W        = 16;
   localparam int unsigned REM_W        = 12;
   localparam int unsigned SEC_W        = 3;
   localparam int unsigned SECTOR_SHIFT = 8;

   localparam logic [HUE_W-1:0] HUE_FULL   = 16'd23040;
   localparam logic [HUE_W-1:0] HUE_SECTOR = 16'd3840;

   // odd part of the sector width, the sector width is this times 2**SECTOR_SHIFT
   localparam int unsigned SECTOR_ODD = 32'(HUE_SECTOR) >> SECTOR_SHIFT;

   typedef logic [SEC_W-1:0] sector_type;

   localparam sector_type SEC_RED     = 3'd0;
   localparam sector_type SEC_YELLOW  = 3'd1;
   localparam sector_type SEC_GREEN   = 3'd2;
   localparam sector_type SEC_CYAN    = 3'd3;
   localparam sector_type SEC_BLUE    = 3'd4;
   localparam sector_type SEC_MAGENTA = 3'd5;

endpackage

`default_nettype wire

>>> rtl/hsv_to_rgb_converter_core.sv
// hsv to rgb converter top level: six-stage pixel pipeline
//
// Input channel: drive req_hue, req_saturation, req_brightness and req_alpha_in
// with start high; the word is taken at the rising edge where start is high and
// busy is low. busy never rises, so one pixel can be taken on every clock.
// Result channel: rsp_valid is high for one cycle with rsp_red, rsp_green,
// rsp_blue and rsp_alpha_out; the word is taken at the edge ending that cycle.
// A pixel taken at one edge passes through every stage in order before it shows
// up on the result ports. Throughput: one pixel per cycle, set by the fully
// pipelined stages (sector split, fraction and p product, fraction fixup, s*f
// products, q/t products, output select).
// Hue at or past a full turn counts as zero; saturation and brightness above
// one are clamped; zero saturation gives gray. Alpha passes unchanged.
// Reset clears all valid bits, so no result appears from words in flight.
// The receiver cannot stall; the pipeline never holds.
`default_nettype none
`include "hsv_to_rgb_converter_core_macros.svh"

module hsv_to_rgb_converter_core #(
   parameter int unsigned FRAC_BITS = 12
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [hsvrgb_pkg::HUE_W-1:0]   req_hue,
   input  wire logic [FRAC_BITS:0]             req_saturation,
   input  wire logic [FRAC_BITS:0]             req_brightness,
   input  wire logic [FRAC_BITS:0]             req_alpha_in,
   output logic                                rsp_valid,
   output logic      [FRAC_BITS:0]             rsp_red,
   output logic      [FRAC_BITS:0]             rsp_green,
   output logic      [FRAC_BITS:0]             rsp_blue,
   output logic      [FRAC_BITS:0]             rsp_alpha_out
);

   localparam int unsigned CH_W   = FRAC_BITS + 1;
   localparam int unsigned PROD_W = 2 * CH_W;
   localparam logic [CH_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   logic accept;

   // stage 1: clamp, wrap, sector split
   logic [hsvrgb_pkg::HUE_W-1:0] hue_wrap;
   logic [hsvrgb_pkg::HUE_W-1:0] hue_base;
   hsvrgb_pkg::sector_type       sec_in;
   logic [hsvrgb_pkg::REM_W-1:0] rem_in;
   logic [CH_W-1:0]              sat_in;
   logic [CH_W-1:0]              bri_in;
   logic                         gray_in;

   logic                         vld1_ff;
   hsvrgb_pkg::sector_type       sec1_ff;
   logic [hsvrgb_pkg::REM_W-1:0] rem1_ff;
   logic [CH_W-1:0]              s1_ff;
   logic [CH_W-1:0]              v1_ff;
   logic [CH_W-1:0]              a1_ff;
   logic                         gray1_ff;

   // stage 2: p product
   logic [PROD_W-1:0]            pprod_in;
   logic                         vld2_ff;
   hsvrgb_pkg::sector_type       sec2_ff;
   logic [CH_W-1:0]              s2_ff;
   logic [CH_W-1:0]              v2_ff;
   logic [CH_W-1:0]              a2_ff;
   logic                         gray2_ff;
   logic [PROD_W-1:0]            pprod2_ff;

   // stage 3: p and fraction
   logic [FRAC_BITS-1:0]         frac3;
   logic                         vld3_ff;
   hsvrgb_pkg::sector_type       sec3_ff;
   logic [CH_W-1:0]              s3_ff;
   logic [CH_W-1:0]              v3_ff;
   logic [CH_W-1:0]              a3_ff;
   logic                         gray3_ff;
   logic [CH_W-1:0]              p3_ff;

   // stage 4: s*f and s*(1-f)
   logic [PROD_W-1:0]            sf_in;
   logic [PROD_W-1:0]            smf_in;
   logic                         vld4_ff;
   hsvrgb_pkg::sector_type       sec4_ff;
   logic [CH_W-1:0]              v4_ff;
   logic [CH_W-1:0]              a4_ff;
   logic                         gray4_ff;
   logic [CH_W-1:0]              p4_ff;
   logic [PROD_W-1:0]            sf4_ff;
   logic [PROD_W-1:0]            smf4_ff;

   // stage 5: q and t products
   logic [CH_W-1:0]              qfac;
   logic [CH_W-1:0]              tfac;
   logic [PROD_W-1:0]            qprod_in;
   logic [PROD_W-1:0]            tprod_in;
   logic                         vld5_ff;
   hsvrgb_pkg::sector_type       sec5_ff;
   logic [CH_W-1:0]              v5_ff;
   logic [CH_W-1:0]              a5_ff;
   logic                         gray5_ff;
   logic [CH_W-1:0]              p5_ff;
   logic [PROD_W-1:0]            qprod5_ff;
   logic [PROD_W-1:0]            tprod5_ff;

   // stage 6: output select
   logic [CH_W-1:0]              q6;
   logic [CH_W-1:0]              t6;
   logic [CH_W-1:0]              red_in;
   logic [CH_W-1:0]              green_in;
   logic [CH_W-1:0]              blue_in;
   logic                         valid_ff;
   logic [CH_W-1:0]              red_ff;
   logic [CH_W-1:0]              green_ff;
   logic [CH_W-1:0]              blue_ff;
   logic [CH_W-1:0]              alpha_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      hue_wrap = (req_hue >= hsvrgb_pkg::HUE_FULL) ? '0 : req_hue;
      if (hue_wrap >= hsvrgb_pkg::HUE_SECTOR * 16'd5) begin
         sec_in   = hsvrgb_pkg::SEC_MAGENTA;
         hue_base = hsvrgb_pkg::HUE_SECTOR * 16'd5;
      end else if (hue_wrap >= hsvrgb_pkg::HUE_SECTOR * 16'd4) begin
         sec_in   = hsvrgb_pkg::SEC_BLUE;
         hue_base = hsvrgb_pkg::HUE_SECTOR * 16'd4;
      end else if (hue_wrap >= hsvrgb_pkg::HUE_SECTOR * 16'd3) begin
         sec_in   = hsvrgb_pkg::SEC_CYAN;
         hue_base = hsvrgb_pkg::HUE_SECTOR * 16'd3;
      end else if (hue_wrap >= hsvrgb_pkg::HUE_SECTOR * 16'd2) begin
         sec_in   = hsvrgb_pkg::SEC_GREEN;
         hue_base = hsvrgb_pkg::HUE_SECTOR * 16'd2;
      end else if (hue_wrap >= hsvrgb_pkg::HUE_SECTOR) begin
         sec_in   = hsvrgb_pkg::SEC_YELLOW;
         hue_base = hsvrgb_pkg::HUE_SECTOR;
      end else begin
         sec_in   = hsvrgb_pkg::SEC_RED;
         hue_base = '0;
      end
      rem_in  = hsvrgb_pkg::REM_W'(hue_wrap - hue_base);
      sat_in  = (req_saturation > ONE) ? ONE : req_saturation;
      bri_in  = (req_brightness > ONE) ? ONE : req_brightness;
      gray_in = (sat_in == '0);
   end

   always_comb begin
      pprod_in = PROD_W'(v1_ff) * PROD_W'(ONE - s1_ff);
      sf_in    = PROD_W'(s3_ff) * PROD_W'(frac3);
      smf_in   = PROD_W'(s3_ff) * PROD_W'(ONE - CH_W'(frac3));
      qfac     = ONE - sf4_ff[FRAC_BITS +: CH_W];
      tfac     = ONE - smf4_ff[FRAC_BITS +: CH_W];
      qprod_in = PROD_W'(v4_ff) * PROD_W'(qfac);
      tprod_in = PROD_W'(v4_ff) * PROD_W'(tfac);
   end

   hsvrgb_frac #(
      .FRAC_BITS (FRAC_BITS)
   ) u_frac (
      .clock (clock),
      .rem   (rem1_ff),
      .frac  (frac3)
   );

   always_comb begin
      q6 = qprod5_ff[FRAC_BITS +: CH_W];
      t6 = tprod5_ff[FRAC_BITS +: CH_W];
      if (gray5_ff) begin
         red_in   = v5_ff;
         green_in = v5_ff;
         blue_in  = v5_ff;
      end else begin
         case (sec5_ff)
            hsvrgb_pkg::SEC_RED: begin
               red_in = v5_ff; green_in = t6; blue_in = p5_ff;
            end
            hsvrgb_pkg::SEC_YELLOW: begin
               red_in = q6; green_in = v5_ff; blue_in = p5_ff;
            end
            hsvrgb_pkg::SEC_GREEN: begin
               red_in = p5_ff; green_in = v5_ff; blue_in = t6;
            end
            hsvrgb_pkg::SEC_CYAN: begin
               red_in = p5_ff; green_in = q6; blue_in = v5_ff;
            end
            hsvrgb_pkg::SEC_BLUE: begin
               red_in = t6; green_in = p5_ff; blue_in = v5_ff;
            end
            hsvrgb_pkg::SEC_MAGENTA: begin
               red_in = v5_ff; green_in = p5_ff; blue_in = q6;
            end
            default: begin
               red_in = v5_ff; green_in = p5_ff; blue_in = q6;
            end
         endcase
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff  <= 1'b0;
         vld2_ff  <= 1'b0;
         vld3_ff  <= 1'b0;
         vld4_ff  <= 1'b0;
         vld5_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         vld1_ff  <= accept;
         vld2_ff  <= vld1_ff;
         vld3_ff  <= vld2_ff;
         vld4_ff  <= vld3_ff;
         vld5_ff  <= vld4_ff;
         valid_ff <= vld5_ff;
      end
   end

   // data path
   always_ff @(posedge clock) begin
      sec1_ff   <= sec_in;
      rem1_ff   <= rem_in;
      s1_ff     <= sat_in;
      v1_ff     <= bri_in;
      a1_ff     <= req_alpha_in;
      gray1_ff  <= gray_in;

      sec2_ff   <= sec1_ff;
      s2_ff     <= s1_ff;
      v2_ff     <= v1_ff;
      a2_ff     <= a1_ff;
      gray2_ff  <= gray1_ff;
      pprod2_ff <= pprod_in;

      sec3_ff   <= sec2_ff;
      s3_ff     <= s2_ff;
      v3_ff     <= v2_ff;
      a3_ff     <= a2_ff;
      gray3_ff  <= gray2_ff;
      p3_ff     <= pprod2_ff[FRAC_BITS +: CH_W];

      sec4_ff   <= sec3_ff;
      v4_ff     <= v3_ff;
      a4_ff     <= a3_ff;
      gray4_ff  <= gray3_ff;
      p4_ff     <= p3_ff;
      sf4_ff    <= sf_in;
      smf4_ff   <= smf_in;

      sec5_ff   <= sec4_ff;
      v5_ff     <= v4_ff;
      a5_ff     <= a4_ff;
      gray5_ff  <= gray4_ff;
      p5_ff     <= p4_ff;
      qprod5_ff <= qprod_in;
      tprod5_ff <= tprod_in;

      red_ff    <= red_in;
      green_ff  <= green_in;
      blue_ff   <= blue_in;
      alpha_ff  <= a5_ff;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_red       = red_ff;
   assign rsp_green     = green_ff;
   assign rsp_blue      = blue_ff;
   assign rsp_alpha_out = alpha_ff;

   `HSVRGB_ASSERT(a_word_out_after_six, accept |-> ##6 rsp_valid)
   `HSVRGB_ASSERT(a_no_invented_word, rsp_valid |-> $past(accept, 6))
   `HSVRGB_ASSERT_CR(a_alpha_kept, clock, reset, vld1_ff |-> ##5 (rsp_alpha_out == $past(a1_ff, 5)))
   `HSVRGB_ASSERT(a_max_channel_is_value, rsp_valid |-> (rsp_red == $past(v5_ff) || rsp_green == $past(v5_ff) || rsp_blue == $past(v5_ff)))

endmodule

`default_nettype wire

>>> rtl/hsvrgb_frac.sv
// two-stage fraction unit: (rem << FRAC_BITS) / sector width by reciprocal multiply
`default_nettype none

module hsvrgb_frac #(
   parameter int unsigned FRAC_BITS = 12
) (
   input  wire logic                          clock,
   input  wire logic [hsvrgb_pkg::REM_W-1:0]  rem,
   output logic      [FRAC_BITS-1:0]          frac
);

   localparam int unsigned YW   = hsvrgb_pkg::REM_W + FRAC_BITS - hsvrgb_pkg::SECTOR_SHIFT;
   localparam int unsigned K    = YW + 4;
   localparam int unsigned MW   = K - 3;
   localparam int unsigned PW   = YW + MW;
   localparam int unsigned QW   = PW - K;
   localparam logic [MW-1:0] MUL =
      MW'((64'd1 << K) / 64'(hsvrgb_pkg::SECTOR_ODD));
   localparam logic [YW-1:0] ODD = YW'(hsvrgb_pkg::SECTOR_ODD);

   logic [YW-1:0]        y_in;
   logic [YW-1:0]        y_ff;
   logic [PW-1:0]        prod_in;
   logic [PW-1:0]        prod_ff;
   logic [QW-1:0]        est;
   logic [YW+3:0]        est_x_odd;
   logic [YW-1:0]        resid;
   logic [FRAC_BITS-1:0] frac_in;
   logic [FRAC_BITS-1:0] frac_ff;

   // low bits of the sector width are a plain shift
   always_comb begin
      y_in    = YW'(rem) << (FRAC_BITS - hsvrgb_pkg::SECTOR_SHIFT);
      prod_in = PW'(y_in) * PW'(MUL);
   end

   // estimate is low by at most one, fix with one compare
   always_comb begin
      est       = prod_ff[K +: QW];
      est_x_odd = (YW+4)'(est) * (YW+4)'(ODD);
      resid     = y_ff - YW'(est_x_odd);
      frac_in   = (resid >= ODD) ? FRAC_BITS'(est + QW'(1)) : FRAC_BITS'(est);
   end

   always_ff @(posedge clock) begin
      y_ff    <= y_in;
      prod_ff <= prod_in;
      frac_ff <= frac_in;
   end

   assign frac = frac_ff;

endmodule

`default_nettype wire
